// ===== sv/hqp_pkg.sv =====
`timescale 1ns / 1ps

package hqp_pkg;

	localparam int KEY_W = 31;
	localparam int PAYLOAD_W = 64;
	localparam int IN_W = 96;

	localparam int HASH_MODULUS = 5;
	// remainder before correction lies in [0, 2*HASH_MODULUS)
	localparam int REM_W = $clog2(2 * HASH_MODULUS);
	localparam int R_W = $clog2(HASH_MODULUS + 1);
	localparam logic [31:0] HASH_RECIP = 32'((64'd1 << 31) / HASH_MODULUS);

	typedef enum logic [1:0] {
		STATUS_OK       = 2'd0,
		STATUS_FULL     = 2'd1,
		STATUS_KEY_ZERO = 2'd2
	} hqp_status_t;

endpackage

// ===== sv/hqp_ram.sv =====
`timescale 1ns / 1ps

module hqp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== sv/hash_table_quadratic_probe_top.sv =====
`timescale 1ns / 1ps

// Open-addressing hash table, one search or insert per transaction. After reset the key store
// is swept clear, one slot a cycle, before s_tready first rises. An accepted request passes
// through ST_HASH_MUL, ST_HASH_SUB, ST_HOME_MUL, ST_HOME_SUB and ST_HOME to form the home
// slot (key mod 5, then mod TABLE_SIZE), then reads the key and payload stores once per cycle
// along the quadratic probe sequence; after n probes (1 to TABLE_SIZE) the result is loaded
// into the output register once it is free, and a key of zero skips the hashing and probing.
// The key store has a single read port. One request is in flight at a time; the next is taken
// as soon as the previous result sits in the output register, even while it waits.
module hash_table_quadratic_probe_top #(
	parameter int TABLE_SIZE = 32,
	localparam int SLOT_W = $clog2(TABLE_SIZE),
	localparam int CNT_W = $clog2(TABLE_SIZE + 1),
	localparam int OUT_BITS = 1 + SLOT_W + hqp_pkg::PAYLOAD_W + 2 + CNT_W,
	localparam int OUT_W = ((OUT_BITS + 7) / 8) * 8
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_tvalid,
	output logic                     s_tready,
	input  logic [hqp_pkg::IN_W-1:0] s_tdata,  // key, payload
	input  logic                     s_tuser,  // action
	output logic                     m_tvalid,
	input  logic                     m_tready,
	output logic [OUT_W-1:0]         m_tdata   // found, slot, stored_payload, status, occupied_count
);

	import hqp_pkg::*;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_HASH_MUL,
		ST_HASH_SUB,
		ST_HOME_MUL,
		ST_HOME_SUB,
		ST_HOME,
		ST_PROBE,
		ST_DONE
	} state_t;

	localparam logic [SLOT_W:0] TS_X = (SLOT_W + 1)'(TABLE_SIZE);
	localparam logic [R_W-1:0] HOME_RECIP = R_W'((1 << R_W) / TABLE_SIZE);

	function automatic logic [SLOT_W-1:0] mod_add(input logic [SLOT_W-1:0] a,
			input logic [SLOT_W-1:0] b);
		logic [SLOT_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return (s >= TS_X) ? SLOT_W'(s - TS_X) : s[SLOT_W-1:0];
	endfunction

	function automatic logic [SLOT_W-1:0] mod_sub(input logic [SLOT_W-1:0] a,
			input logic [SLOT_W-1:0] b);
		return (a >= b) ? SLOT_W'(a - b) : SLOT_W'({1'b0, a} + TS_X - {1'b0, b});
	endfunction

	state_t              state_q;
	logic [SLOT_W-1:0]   clr_addr_q;
	logic [CNT_W-1:0]    issue_cnt_q;
	logic                rd_vld_s1;
	logic                wr_key_q;
	logic                wr_pay_q;
	logic [CNT_W-1:0]    occ_q;
	logic                m_tvalid_q;
	logic [OUT_W-1:0]    m_tdata_q;

	logic                act_q;
	logic [KEY_W-1:0]    key_q;
	logic [PAYLOAD_W-1:0] pay_q;
	logic [62:0]         prod_s1;
	logic [REM_W-1:0]    rem_s2;
	logic [R_W-1:0]      r_s3;
	logic [2*R_W-1:0]    prod2_s3;
	logic [SLOT_W:0]     rem2_s4;
	logic [SLOT_W-1:0]   home_q;
	logic [SLOT_W-1:0]   off_q;
	logic [SLOT_W-1:0]   step_q;
	logic [SLOT_W-1:0]   pos_q;
	logic [SLOT_W-1:0]   rd_pos_s1;
	logic                rd_last_s1;
	logic                res_found_q;
	logic [SLOT_W-1:0]   res_slot_q;
	logic [PAYLOAD_W-1:0] res_pay_q;
	hqp_status_t         res_status_q;

	logic                 s_acc;
	logic                 out_free;
	logic                 rd_en;
	logic [KEY_W-1:0]     key_rd;
	logic [PAYLOAD_W-1:0] pay_rd;
	logic                 key_hit;
	logic                 key_empty;
	logic                 probe_stop;
	logic                 probe_full;
	logic [SLOT_W-1:0]    off_nx;
	logic [SLOT_W-1:0]    step_nx;
	logic [SLOT_W-1:0]    pos_plus;
	logic [SLOT_W-1:0]    pos_minus;
	logic [REM_W-1:0]     hash_rem;
	logic [R_W-1:0]       hash_r;
	logic [R_W-1:0]       home_q2;
	logic [SLOT_W-1:0]    home_nx;
	logic [CNT_W-1:0]     occ_nx;
	logic                 key_we;
	logic [SLOT_W-1:0]    key_waddr;
	logic [KEY_W-1:0]     key_wdata;
	logic                 pay_we;

	assign s_tready = (state_q == ST_IDLE);
	assign s_acc    = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	assign rd_en = (state_q == ST_PROBE) && (issue_cnt_q != CNT_W'(TABLE_SIZE));

	assign key_hit    = (key_rd == key_q);
	assign key_empty  = (key_rd == '0);
	assign probe_stop = rd_vld_s1 && (key_hit || key_empty);
	assign probe_full = rd_vld_s1 && !(key_hit || key_empty) && rd_last_s1;

	// k^2 advances by 2k+1, kept as a running step
	assign off_nx    = mod_add(off_q, step_q);
	assign step_nx   = mod_add(step_q, SLOT_W'(2));
	assign pos_plus  = mod_add(home_q, off_nx);
	assign pos_minus = mod_sub(home_q, off_q);

	assign hash_rem = (rem_s2 >= REM_W'(HASH_MODULUS)) ? REM_W'(rem_s2 - REM_W'(HASH_MODULUS))
			: rem_s2;
	assign hash_r   = R_W'(hash_rem);
	assign home_q2  = prod2_s3[2*R_W-1:R_W];
	assign home_nx  = (rem2_s4 >= TS_X) ? SLOT_W'(rem2_s4 - TS_X) : rem2_s4[SLOT_W-1:0];
	assign occ_nx   = wr_key_q ? CNT_W'(occ_q + 1'b1) : occ_q;

	assign key_we    = (state_q == ST_CLEAR) || ((state_q == ST_DONE) && out_free && wr_key_q);
	assign key_waddr = (state_q == ST_CLEAR) ? clr_addr_q : res_slot_q;
	assign key_wdata = (state_q == ST_CLEAR) ? '0 : key_q;
	assign pay_we    = (state_q == ST_DONE) && out_free && wr_pay_q;

	hqp_ram #(
		.WIDTH(KEY_W),
		.DEPTH(TABLE_SIZE)
	) u_key_ram (
		.clk  (clk),
		.we   (key_we),
		.waddr(key_waddr),
		.wdata(key_wdata),
		.re   (rd_en),
		.raddr(pos_q),
		.rdata(key_rd)
	);

	hqp_ram #(
		.WIDTH(PAYLOAD_W),
		.DEPTH(TABLE_SIZE)
	) u_pay_ram (
		.clk  (clk),
		.we   (pay_we),
		.waddr(res_slot_q),
		.wdata(pay_q),
		.re   (rd_en),
		.raddr(pos_q),
		.rdata(pay_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_addr_q  <= '0;
			issue_cnt_q <= '0;
			rd_vld_s1   <= 1'b0;
			wr_key_q    <= 1'b0;
			wr_pay_q    <= 1'b0;
			occ_q       <= '0;
			m_tvalid_q  <= 1'b0;
			m_tdata_q   <= '0;
		end else begin
			if ((state_q == ST_DONE) && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_addr_q <= SLOT_W'(clr_addr_q + 1'b1);
					if (clr_addr_q == SLOT_W'(TABLE_SIZE - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (s_acc) begin
						wr_key_q <= 1'b0;
						wr_pay_q <= 1'b0;
						state_q  <= (s_tdata[KEY_W-1:0] == '0) ? ST_DONE : ST_HASH_MUL;
					end
				end
				ST_HASH_MUL: state_q <= ST_HASH_SUB;
				ST_HASH_SUB: state_q <= ST_HOME_MUL;
				ST_HOME_MUL: state_q <= ST_HOME_SUB;
				ST_HOME_SUB: state_q <= ST_HOME;
				ST_HOME: begin
					issue_cnt_q <= '0;
					rd_vld_s1   <= 1'b0;
					state_q     <= ST_PROBE;
				end
				ST_PROBE: begin
					rd_vld_s1 <= rd_en && !(probe_stop || probe_full);
					if (rd_en) begin
						issue_cnt_q <= CNT_W'(issue_cnt_q + 1'b1);
					end
					if (probe_stop || probe_full) begin
						wr_key_q  <= probe_stop && !key_hit && act_q;
						wr_pay_q  <= probe_stop && act_q;
						state_q   <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						m_tdata_q  <= OUT_W'({occ_nx, res_status_q, res_pay_q, res_slot_q,
								res_found_q});
						occ_q      <= occ_nx;
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (s_acc) begin
					act_q        <= s_tuser;
					key_q        <= s_tdata[KEY_W-1:0];
					pay_q        <= s_tdata[KEY_W+PAYLOAD_W-1:KEY_W];
					res_found_q  <= 1'b0;
					res_slot_q   <= '0;
					res_pay_q    <= '0;
					res_status_q <= (s_tdata[KEY_W-1:0] == '0) ? STATUS_KEY_ZERO : STATUS_OK;
				end
			end
			ST_HASH_MUL: begin
				prod_s1 <= {32'd0, key_q} * {31'd0, HASH_RECIP};
			end
			ST_HASH_SUB: begin
				// quotient estimate is low by at most one
				rem_s2 <= REM_W'(key_q) - REM_W'(prod_s1[62:31]) * REM_W'(HASH_MODULUS);
			end
			ST_HOME_MUL: begin
				r_s3     <= hash_r;
				prod2_s3 <= {{R_W{1'b0}}, hash_r} * {{R_W{1'b0}}, HOME_RECIP};
			end
			ST_HOME_SUB: begin
				rem2_s4 <= (SLOT_W + 1)'(r_s3) - (SLOT_W + 1)'(home_q2) * TS_X;
			end
			ST_HOME: begin
				home_q <= home_nx;
				pos_q  <= home_nx;
				off_q  <= '0;
				step_q <= SLOT_W'(1);
			end
			ST_PROBE: begin
				if (rd_en) begin
					rd_pos_s1  <= pos_q;
					rd_last_s1 <= (issue_cnt_q == CNT_W'(TABLE_SIZE - 1));
					if (!issue_cnt_q[0]) begin
						off_q  <= off_nx;
						step_q <= step_nx;
						pos_q  <= pos_plus;
					end else begin
						pos_q <= pos_minus;
					end
				end
				if (probe_full) begin
					res_status_q <= STATUS_FULL;
				end else if (probe_stop) begin
					res_found_q <= key_hit;
					if (key_hit || act_q) begin
						res_slot_q <= rd_pos_s1;
						res_pay_q  <= act_q ? pay_q : pay_rd;
					end
				end
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== sv/hqp_checker.sv =====
`timescale 1ns / 1ps

module hqp_checker #(
	parameter int TABLE_SIZE = 32,
	localparam int SLOT_W = $clog2(TABLE_SIZE),
	localparam int CNT_W = $clog2(TABLE_SIZE + 1),
	localparam int OUT_BITS = 1 + SLOT_W + hqp_pkg::PAYLOAD_W + 2 + CNT_W,
	localparam int OUT_W = ((OUT_BITS + 7) / 8) * 8
) (
	input logic             clk,
	input logic             arst_n,
	input logic             s_tvalid,
	input logic             s_tready,
	input logic             m_tvalid,
	input logic             m_tready,
	input logic [OUT_W-1:0] m_tdata
);

	import hqp_pkg::*;

	localparam int PAY_LO = 1 + SLOT_W;
	localparam int STAT_LO = PAY_LO + PAYLOAD_W;
	localparam int CNT_LO = STAT_LO + 2;

	logic                 found;
	logic [SLOT_W-1:0]    slot;
	logic [PAYLOAD_W-1:0] stored_payload;
	logic [1:0]           status;
	logic [CNT_W-1:0]     occupied_count;

	assign found          = m_tdata[0];
	assign slot           = m_tdata[SLOT_W:1];
	assign stored_payload = m_tdata[STAT_LO-1:PAY_LO];
	assign status         = m_tdata[CNT_LO-1:STAT_LO];
	assign occupied_count = m_tdata[CNT_LO+CNT_W-1:CNT_LO];

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("request taken while another is in flight");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("stalled result changed");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (occupied_count <= CNT_W'(TABLE_SIZE)))
		else $error("occupancy beyond table size");

	a_reject_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (status != STATUS_OK)) |-> (!found && (slot == '0) && (stored_payload == '0)))
		else $error("rejected request carries data");

	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && found) |-> (status == STATUS_OK))
		else $error("hit reported with error status");

endmodule

bind hash_table_quadratic_probe_top hqp_checker #(.TABLE_SIZE(TABLE_SIZE)) u_hqp_checker (.*);
